// ===== rtl/irpdt_pkg.sv =====
// ----------------------------------------------------------------------------
// irpdt_pkg
// Shared types and constants of the infrared pulse-distance transmitter.
// ----------------------------------------------------------------------------
`default_nettype none

package irpdt_pkg;

   localparam int TIME_W     = 16;
   localparam int DATA_W     = 8;
   localparam int CSR_IDX_W  = 3;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW   = $clog2(QUEUE_DEPTH);

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_LEADER_MARK  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LEADER_SPACE = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BIT_MARK     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ZERO_SPACE   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ONE_SPACE    = 3'd4;

   // Register values after reset.
   localparam logic [TIME_W-1:0] RST_LEADER_MARK  = 16'd1363;
   localparam logic [TIME_W-1:0] RST_LEADER_SPACE = 16'd691;
   localparam logic [TIME_W-1:0] RST_BIT_MARK     = 16'd85;
   localparam logic [TIME_W-1:0] RST_ZERO_SPACE   = 16'd85;
   localparam logic [TIME_W-1:0] RST_ONE_SPACE    = 16'd236;

   // Hold time of the idle segment at the end of a frame.
   localparam logic [TIME_W-1:0] IDLE_TIME = '0;

   typedef struct packed {
      logic [DATA_W-1:0] data_byte;
      logic              byte_present;
      logic              frame_start;
      logic              frame_end;
   } req_type;

   typedef struct packed {
      logic              line_level;
      logic [TIME_W-1:0] segment_time;
      logic              run_last;
   } rsp_type;

   typedef struct packed {
      logic [TIME_W-1:0] leader_mark_time;
      logic [TIME_W-1:0] leader_space_time;
      logic [TIME_W-1:0] bit_mark_time;
      logic [TIME_W-1:0] zero_space_time;
      logic [TIME_W-1:0] one_space_time;
   } cfg_type;

   // Handshake between the command queue and its neighbors.
   typedef struct packed {
      logic push;
      logic pop;
   } q_ctl_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_stat_type;

   typedef enum logic [3:0] {
      PH_IDLE   = 4'b0001,
      PH_LEADER = 4'b0010,
      PH_BITS   = 4'b0100,
      PH_STOP   = 4'b1000
   } phase_type;

endpackage

`default_nettype wire

// ===== rtl/irpdt_front.sv =====
// ----------------------------------------------------------------------------
// irpdt_front
// Input stage: registers accepted items and drops those that ask for nothing.
// ----------------------------------------------------------------------------
`default_nettype none

module irpdt_front (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       req_push,
   output logic                      req_full,
   input  irpdt_pkg::req_type        req_data,
   input  irpdt_pkg::q_stat_type     q_stat,
   output logic                      q_push,
   output irpdt_pkg::req_type        cmd_out
);
   import irpdt_pkg::*;

   logic    valid_ff, valid_in;
   req_type cmd_ff, cmd_in;
   logic    accept;
   logic    has_work;

   assign q_push   = valid_ff && !q_stat.full;
   assign req_full = valid_ff && q_stat.full;
   assign accept   = req_push && !req_full;
   assign cmd_out  = cmd_ff;

   // An item with no flag set causes no segment, so it never enters the queue.
   assign has_work = req_data.frame_start || req_data.byte_present || req_data.frame_end;

   always_comb begin
      valid_in = valid_ff && !q_push;
      cmd_in   = cmd_ff;
      if (accept && has_work) begin
         valid_in = 1'b1;
         cmd_in   = req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      cmd_ff <= cmd_in;
   end

   a_front_has_work: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (cmd_ff.frame_start || cmd_ff.byte_present || cmd_ff.frame_end))
      else $error("front holds an item that asks for no segment");

endmodule

`default_nettype wire

// ===== rtl/irpdt_queue.sv =====
// ----------------------------------------------------------------------------
// irpdt_queue
// Short command queue between the input stage and the segment sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module irpdt_queue (
   input  wire                       clock,
   input  wire                       reset,
   input  irpdt_pkg::q_ctl_type      q_ctl,
   output irpdt_pkg::q_stat_type     q_stat,
   input  irpdt_pkg::req_type        wr_cmd,
   output irpdt_pkg::req_type        rd_cmd
);
   import irpdt_pkg::*;

   req_type               entry_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]     count_ff, count_in;
   logic                  do_push, do_pop;

   assign q_stat.full  = (count_ff == (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign q_stat.empty = (count_ff == '0);
   assign do_push      = q_ctl.push && !q_stat.full;
   assign do_pop       = q_ctl.pop && !q_stat.empty;
   assign rd_cmd       = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= wr_cmd;
      end
   end

   a_queue_count: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (QUEUE_AW+1)'(QUEUE_DEPTH))
      else $error("command queue count beyond its depth");

endmodule

`default_nettype wire

// ===== rtl/irpdt_back.sv =====
// ----------------------------------------------------------------------------
// irpdt_back
// Segment sequencer: walks leader, data bits and stop of one command and
// emits one line segment per cycle into the result register while that register is empty or being read.
// ----------------------------------------------------------------------------
`default_nettype none

module irpdt_back (
   input  wire                       clock,
   input  wire                       reset,
   input  irpdt_pkg::cfg_type        cfg,
   input  irpdt_pkg::q_stat_type     q_stat,
   output logic                      q_pop,
   input  irpdt_pkg::req_type        q_cmd,
   output logic                      rsp_empty,
   input  wire                       rsp_pop,
   output irpdt_pkg::rsp_type        rsp_data
);
   import irpdt_pkg::*;

   phase_type phase_ff, phase_in;
   logic [3:0] cnt_ff, cnt_in;
   req_type   cmd_ff, cmd_in;
   rsp_type   out_ff, out_in;
   logic      out_valid_ff, out_valid_in;
   logic      emit, seg_last, load;
   rsp_type   seg;
   phase_type first_phase;
   logic [DATA_W-1:0] data_bits;

   assign data_bits = cmd_ff.data_byte;

   // Segment for the current phase and count; even counts are marks.
   always_comb begin
      seg.line_level   = !cnt_ff[0];
      seg.segment_time = cfg.bit_mark_time;
      seg_last         = 1'b0;
      case (phase_ff)
         PH_LEADER: begin
            seg.segment_time = cnt_ff[0] ? cfg.leader_space_time : cfg.leader_mark_time;
            seg_last = cnt_ff[0] && !cmd_ff.byte_present && !cmd_ff.frame_end;
         end
         PH_BITS: begin
            if (cnt_ff[0]) begin
               seg.segment_time = data_bits[cnt_ff[3:1]] ? cfg.one_space_time
                                                         : cfg.zero_space_time;
            end
            seg_last = (cnt_ff == 4'd15) && !cmd_ff.frame_end;
         end
         PH_STOP: begin
            if (cnt_ff[0]) begin
               seg.segment_time = IDLE_TIME;
            end
            seg_last = cnt_ff[0];
         end
         default: begin
            seg_last = 1'b0;
         end
      endcase
      seg.run_last = seg_last;
   end

   always_comb begin
      if (q_cmd.frame_start) begin
         first_phase = PH_LEADER;
      end else if (q_cmd.byte_present) begin
         first_phase = PH_BITS;
      end else begin
         first_phase = PH_STOP;
      end
   end

   assign emit  = (phase_ff != PH_IDLE) && (!out_valid_ff || rsp_pop);
   assign load  = !q_stat.empty && ((phase_ff == PH_IDLE) || (emit && seg_last));
   assign q_pop = load;

   always_comb begin
      phase_in = phase_ff;
      cnt_in   = cnt_ff;
      cmd_in   = cmd_ff;
      if (load) begin
         phase_in = first_phase;
         cnt_in   = '0;
         cmd_in   = q_cmd;
      end else if (emit && seg_last) begin
         phase_in = PH_IDLE;
         cnt_in   = '0;
      end else if (emit) begin
         cnt_in = cnt_ff + 1'b1;
         if (phase_ff == PH_LEADER && cnt_ff[0]) begin
            phase_in = cmd_ff.byte_present ? PH_BITS : PH_STOP;
            cnt_in   = '0;
         end else if (phase_ff == PH_BITS && cnt_ff == 4'd15) begin
            phase_in = PH_STOP;
            cnt_in   = '0;
         end
      end
   end

   always_comb begin
      out_valid_in = emit || (out_valid_ff && !rsp_pop);
      out_in       = emit ? seg : out_ff;
   end

   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         cnt_ff       <= cnt_in;
         out_valid_ff <= out_valid_in;
      end
      cmd_ff <= cmd_in;
      out_ff <= out_in;
   end

   a_back_bits_present: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_BITS) |-> cmd_ff.byte_present)
      else $error("bit phase entered for a command without a byte");

   a_back_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_pop) |-> !emit)
      else $error("waiting result overwritten");

   a_back_idle_after_last: assert property (@(posedge clock) disable iff (reset)
      (emit && seg_last && q_stat.empty) |=> (phase_ff == PH_IDLE))
      else $error("sequencer did not go idle after the last segment");

endmodule

`default_nettype wire

// ===== rtl/ir_pulse_distance_transmitter_top.sv =====
// Path: an accepted item passes the input register, the command queue and the
// sequencer before its first segment is registered in the result register.
// Throughput: one segment per cycle while the reader keeps up; an item causes
// 2 to 20 segments, all from the single sequencer, and items follow back to back.
// Reset: synchronous, active high; empties all stages and restores the registers.
// ----------------------------------------------------------------------------
// ir_pulse_distance_transmitter_top
// Turns frame bytes into pulse-distance line segments with programmable times.
// ----------------------------------------------------------------------------
`default_nettype none

module ir_pulse_distance_transmitter_top (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   req_push,
   output logic                                  req_full,
   input  irpdt_pkg::req_type                    req_data,
   output logic                                  rsp_empty,
   input  wire                                   rsp_pop,
   output irpdt_pkg::rsp_type                    rsp_data,
   input  wire                                   csr_write_en,
   input  wire  [irpdt_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire  [irpdt_pkg::TIME_W-1:0]          csr_wdata
);
   import irpdt_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   q_ctl_type  q_ctl;
   q_stat_type q_stat;
   req_type    front_cmd, queue_cmd;
   logic       q_push, q_pop;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_LEADER_MARK:  cfg_in.leader_mark_time  = csr_wdata;
            CSR_LEADER_SPACE: cfg_in.leader_space_time = csr_wdata;
            CSR_BIT_MARK:     cfg_in.bit_mark_time     = csr_wdata;
            CSR_ZERO_SPACE:   cfg_in.zero_space_time   = csr_wdata;
            CSR_ONE_SPACE:    cfg_in.one_space_time    = csr_wdata;
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.leader_mark_time  <= RST_LEADER_MARK;
         cfg_ff.leader_space_time <= RST_LEADER_SPACE;
         cfg_ff.bit_mark_time     <= RST_BIT_MARK;
         cfg_ff.zero_space_time   <= RST_ZERO_SPACE;
         cfg_ff.one_space_time    <= RST_ONE_SPACE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign q_ctl.push = q_push;
   assign q_ctl.pop  = q_pop;

   irpdt_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_full (req_full),
      .req_data (req_data),
      .q_stat   (q_stat),
      .q_push   (q_push),
      .cmd_out  (front_cmd)
   );

   irpdt_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .q_ctl  (q_ctl),
      .q_stat (q_stat),
      .wr_cmd (front_cmd),
      .rd_cmd (queue_cmd)
   );

   irpdt_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_stat    (q_stat),
      .q_pop     (q_pop),
      .q_cmd     (queue_cmd),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// ===== tb/ir_segment_checker.sv =====
// ----------------------------------------------------------------------------
// ir_segment_checker
// Watches the item and segment channels of the pulse-distance transmitter.
// Every accepted item is expanded into the segments that it must produce
// under the current timing registers. Each delivered segment is compared
// field by field with the oldest segment still due.
// ----------------------------------------------------------------------------
module ir_segment_checker (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            req_push,
   input  wire                            req_full,
   input  irpdt_pkg::req_type             req_data,
   input  wire                            rsp_empty,
   input  wire                            rsp_pop,
   input  irpdt_pkg::rsp_type             rsp_data,
   input  wire                            csr_write_en,
   input  wire  [irpdt_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire  [irpdt_pkg::TIME_W-1:0]    csr_wdata,
   output int                             mismatch_count,
   output int                             segments_outstanding
);
   timeunit 1ns;
   timeprecision 1ps;
   import irpdt_pkg::*;

   cfg_type timing;
   rsp_type due_segments[$];
   int      errors = 0;

   task automatic queue_segment(input logic level, input logic [TIME_W-1:0] hold,
                                input logic last);
      rsp_type seg;
      seg.line_level   = level;
      seg.segment_time = hold;
      seg.run_last     = last;
      due_segments.push_back(seg);
   endtask

   // Leader, then the bits, then stop and idle; the final low segment of the
   // run carries the last flag.
   task automatic expand_item(input req_type item);
      if (item.frame_start) begin
         queue_segment(1'b1, timing.leader_mark_time, 1'b0);
         queue_segment(1'b0, timing.leader_space_time,
                       !item.byte_present && !item.frame_end);
      end
      if (item.byte_present) begin
         for (int b = 0; b < DATA_W; b++) begin
            queue_segment(1'b1, timing.bit_mark_time, 1'b0);
            queue_segment(1'b0,
                          item.data_byte[b] ? timing.one_space_time : timing.zero_space_time,
                          (b == DATA_W - 1) && !item.frame_end);
         end
      end
      if (item.frame_end) begin
         queue_segment(1'b1, timing.bit_mark_time, 1'b0);
         queue_segment(1'b0, IDLE_TIME, 1'b1);
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         timing = {RST_LEADER_MARK, RST_LEADER_SPACE, RST_BIT_MARK,
                   RST_ZERO_SPACE, RST_ONE_SPACE};
         due_segments.delete();
      end else begin
         if (req_push && !req_full) begin
            expand_item(req_data);
         end
         if (rsp_pop && !rsp_empty) begin
            if (due_segments.size() == 0) begin
               $display("%0t: segment with none due: level %0b, time %0d, last %0b",
                        $time, rsp_data.line_level, rsp_data.segment_time,
                        rsp_data.run_last);
               errors++;
            end else begin
               want = due_segments.pop_front();
               if (rsp_data.line_level !== want.line_level) begin
                  $display("%0t: line_level expected %0b, got %0b",
                           $time, want.line_level, rsp_data.line_level);
                  errors++;
               end
               if (rsp_data.segment_time !== want.segment_time) begin
                  $display("%0t: segment_time expected %0d, got %0d",
                           $time, want.segment_time, rsp_data.segment_time);
                  errors++;
               end
               if (rsp_data.run_last !== want.run_last) begin
                  $display("%0t: run_last expected %0b, got %0b",
                           $time, want.run_last, rsp_data.run_last);
                  errors++;
               end
            end
         end
         // Timing changes only affect items accepted after this edge.
         if (csr_write_en) begin
            case (csr_index)
               CSR_LEADER_MARK:  timing.leader_mark_time  = csr_wdata;
               CSR_LEADER_SPACE: timing.leader_space_time = csr_wdata;
               CSR_BIT_MARK:     timing.bit_mark_time     = csr_wdata;
               CSR_ZERO_SPACE:   timing.zero_space_time   = csr_wdata;
               CSR_ONE_SPACE:    timing.one_space_time    = csr_wdata;
               default: ;
            endcase
         end
      end
      mismatch_count       <= errors;
      segments_outstanding <= due_segments.size();
   end

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives frame items into the infrared transmitter under several timing
// settings, with random gaps on both channels, a long hold-off of the segment
// reader and a back-to-back burst; the segment checker judges every result.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import irpdt_pkg::*;

   localparam int MAX_GAP       = 19;
   localparam int LONG_HOLD_OFF = 200;
   localparam int SETTLE_CYCLES = 8;
   localparam int STALL_LIMIT   = 2000;
   localparam int RANDOM_BATCH  = 25;

   logic                 clock        = 1'b0;
   logic                 reset        = 1'b1;
   logic                 req_push     = 1'b0;
   logic                 req_full;
   req_type              req_data     = '0;
   logic                 rsp_empty;
   logic                 rsp_pop      = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index    = '0;
   logic [TIME_W-1:0]    csr_wdata    = '0;
   int                   mismatch_count;
   int                   segments_outstanding;
   int                   send_gap_max     = MAX_GAP;
   int                   take_gap_max     = MAX_GAP;
   bit                   hold_off_request = 1'b0;
   int                   quiet_cycles     = 0;

   ir_pulse_distance_transmitter_top u_top (
      .clock        (clock),
      .reset        (reset),
      .req_push     (req_push),
      .req_full     (req_full),
      .req_data     (req_data),
      .rsp_empty    (rsp_empty),
      .rsp_pop      (rsp_pop),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   ir_segment_checker u_checker (
      .clock                (clock),
      .reset                (reset),
      .req_push             (req_push),
      .req_full             (req_full),
      .req_data             (req_data),
      .rsp_empty            (rsp_empty),
      .rsp_pop              (rsp_pop),
      .rsp_data             (rsp_data),
      .csr_write_en         (csr_write_en),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata),
      .mismatch_count       (mismatch_count),
      .segments_outstanding (segments_outstanding)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic send_item(input req_type item);
      int gap;
      gap = (send_gap_max == 0) ? 0 : $urandom_range(0, send_gap_max);
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (req_full);
   endtask

   // Most items form complete frames; one draw in five sends a single random flag mix.
   task automatic send_random_frames(input int count);
      int      sent;
      int      frame_len;
      req_type item;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(0, 9) < 2) begin
            item.data_byte    = 8'($urandom);
            item.byte_present = 1'($urandom);
            item.frame_start  = 1'($urandom);
            item.frame_end    = 1'($urandom);
            send_item(item);
            sent++;
         end else begin
            frame_len = $urandom_range(1, 4);
            if (frame_len > count - sent) begin
               frame_len = count - sent;
            end
            for (int i = 0; i < frame_len; i++) begin
               item.data_byte    = 8'($urandom);
               item.byte_present = 1'b1;
               item.frame_start  = (i == 0);
               item.frame_end    = (i == frame_len - 1);
               send_item(item);
               sent++;
            end
         end
      end
   endtask

   // An item with no flags gives no segment, so some settling time follows.
   task automatic wait_for_quiet();
      req_push <= 1'b0;
      do @(posedge clock); while (segments_outstanding != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic program_timing(input cfg_type t);
      logic [CSR_IDX_W-1:0] stray;
      stray = CSR_IDX_W'($urandom_range(CSR_ONE_SPACE + 1, (1 << CSR_IDX_W) - 1));
      csr_write_en <= 1'b1;
      csr_index    <= CSR_LEADER_MARK;
      csr_wdata    <= t.leader_mark_time;
      @(posedge clock);
      csr_index    <= CSR_LEADER_SPACE;
      csr_wdata    <= t.leader_space_time;
      @(posedge clock);
      csr_index    <= CSR_BIT_MARK;
      csr_wdata    <= t.bit_mark_time;
      @(posedge clock);
      csr_index    <= CSR_ZERO_SPACE;
      csr_wdata    <= t.zero_space_time;
      @(posedge clock);
      csr_index    <= CSR_ONE_SPACE;
      csr_wdata    <= t.one_space_time;
      @(posedge clock);
      // A write past the last register must leave every timing unchanged.
      csr_index    <= stray;
      csr_wdata    <= 16'($urandom);
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   function automatic cfg_type random_timing();
      cfg_type t;
      t.leader_mark_time  = 16'($urandom);
      t.leader_space_time = 16'($urandom);
      t.bit_mark_time     = 16'($urandom);
      t.zero_space_time   = 16'($urandom);
      t.one_space_time    = 16'($urandom);
      return t;
   endfunction

   // Segment reader.
   initial begin
      int gap;
      while (reset) @(posedge clock);
      forever begin
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            gap = LONG_HOLD_OFF;
         end else begin
            gap = (take_gap_max == 0) ? 0 : $urandom_range(0, take_gap_max);
         end
         if (gap > 0) begin
            rsp_pop <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_pop <= 1'b1;
         do @(posedge clock); while (rsp_empty);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   initial begin
      cfg_type t;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed items under the reset timing: byte extremes and every flag mix.
      send_item({8'h00, 1'b1, 1'b1, 1'b1});
      send_item({8'hFF, 1'b1, 1'b1, 1'b1});
      send_item({8'h01, 1'b1, 1'b1, 1'b0});
      send_item({8'h80, 1'b1, 1'b0, 1'b0});
      send_item({8'hA5, 1'b1, 1'b0, 1'b1});
      send_item({8'h5A, 1'b0, 1'b1, 1'b1});
      send_item({8'h00, 1'b0, 1'b0, 1'b0});
      send_item({8'h3C, 1'b0, 1'b1, 1'b0});
      send_item({8'hC3, 1'b0, 1'b0, 1'b1});
      send_item({8'hFF, 1'b0, 1'b0, 1'b0});
      send_item({8'h55, 1'b1, 1'b1, 1'b1});
      send_item({8'hAA, 1'b1, 1'b0, 1'b1});
      send_item({8'h7E, 1'b0, 1'b1, 1'b0});
      send_item({8'h81, 1'b1, 1'b0, 1'b0});
      wait_for_quiet();

      program_timing('0);
      send_random_frames(RANDOM_BATCH);
      wait_for_quiet();

      // Full speed on both channels.
      program_timing('1);
      send_gap_max = 0;
      take_gap_max = 0;
      send_random_frames(RANDOM_BATCH);
      wait_for_quiet();

      // The reader holds off while items arrive back to back, filling the block.
      take_gap_max = MAX_GAP;
      program_timing(random_timing());
      hold_off_request = 1'b1;
      send_random_frames(RANDOM_BATCH);
      wait_for_quiet();

      send_gap_max = MAX_GAP;
      t = random_timing();
      t.leader_mark_time = 16'd1;
      t.zero_space_time  = '0;
      t.one_space_time   = '1;
      program_timing(t);
      send_random_frames(RANDOM_BATCH);
      wait_for_quiet();

      if (mismatch_count == 0 && segments_outstanding == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// ===== ir_pulse_distance_transmitter_top.f =====
rtl/irpdt_pkg.sv
rtl/irpdt_front.sv
rtl/irpdt_queue.sv
rtl/irpdt_back.sv
rtl/ir_pulse_distance_transmitter_top.sv
tb/ir_segment_checker.sv
tb/testbench.sv
